>>> hw/rtl/srg_pkg.sv
// srg_pkg: shared constants and types of the setpoint ramp generator
// depends on nothing; used by every other file of the block
`default_nettype none

package srg_pkg;

	// timer ticks in one second; zero falls back to one
	localparam int unsigned TICKS_PER_SECOND = 1000;
	localparam int unsigned TICK_DIV = (TICKS_PER_SECOND == 0) ? 1 : TICKS_PER_SECOND;

	localparam int unsigned VALUE_W = 16;
	localparam int unsigned FRAC_W  = 16;
	localparam int unsigned TIMER_W = 16;
	localparam int unsigned RATE_W  = 16;

	// reciprocal of the tick divisor, exact for any 16-bit dividend
	localparam int unsigned RECIP_SHIFT = 32;
	localparam int unsigned RECIP_W     = 33;
	localparam logic [RECIP_W-1:0] TICK_RECIP =
		RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(TICK_DIV) + 64'd1);

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_UP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_DOWN = 2'd1;

	// operation codes
	localparam logic OP_STEP   = 1'b0;
	localparam logic OP_PRESET = 1'b1;

	// item after the input stage: timer already reduced to whole seconds
	typedef struct packed {
		logic                      operation;
		logic signed [VALUE_W-1:0] target_value;
		logic [TIMER_W-1:0]        seconds;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] ramp_out;
		logic                      at_target;
	} result_t;

endpackage

`default_nettype wire

>>> hw/rtl/srg_if.sv
// srg_if: valid/ready channels for step items and ramp results
// depends on srg_pkg
`default_nettype none

interface srg_step_if;
	logic                               valid;
	logic                               ready;
	logic                               operation;
	logic signed [srg_pkg::VALUE_W-1:0] target_value;
	logic [srg_pkg::TIMER_W-1:0]        timer_now;

	modport source (output valid, output operation, output target_value, output timer_now,
		input ready);
	modport sink (input valid, input operation, input target_value, input timer_now,
		output ready);
endinterface

interface srg_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [srg_pkg::VALUE_W-1:0] ramp_out;
	logic                               at_target;

	modport source (output valid, output ramp_out, output at_target, input ready);
	modport sink (input valid, input ramp_out, input at_target, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/setpoint_ramp_generator_core.sv
// setpoint_ramp_generator_core: top level of the slew-limited setpoint ramp
// depends on srg_pkg, srg_if, srg_in_stage and srg_ramp_stage
`default_nettype none

// Slew-rate limited setpoint ramp. Every step transaction carries a target and
// the current value of a free-running 16-bit tick counter; the block measures
// whole seconds since the previous transaction (ticks / TICKS_PER_SECOND, rest
// dropped) and moves a 16.16 output accumulator toward the target by rate_up or
// rate_down per second, saturating at the target. A preset transaction loads
// the output, clears the fraction and restarts the time base. Each transaction
// gives one result transaction. An accepted transaction is held in the input
// register and moves on to the result register once that register is empty or
// its result is being taken. The tick divide is a reciprocal multiply ahead of
// the input register; the accumulator update and the clamp sit between the
// input register and the result register. Throughput is one transaction per
// cycle while results are taken; while a finished result waits, one more
// transaction is still taken into the input register, and only with both
// registers full does the input stall. Write rate_up and rate_down only while
// no transaction is in flight.
module setpoint_ramp_generator_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write port
	input  wire logic                            cfg_we,
	input  wire logic [srg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [srg_pkg::RATE_W-1:0]      cfg_data,
	// channels
	srg_step_if.sink                             step_ch,
	srg_result_if.source                         result_ch
);

	logic [srg_pkg::RATE_W-1:0] rate_up_q;
	logic [srg_pkg::RATE_W-1:0] rate_down_q;

	logic             valid_s1;
	srg_pkg::item_t   item_s1;
	logic             take;
	logic             valid_s2;
	srg_pkg::result_t result_s2;

	// configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_up_q   <= '0;
			rate_down_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				srg_pkg::REG_RATE_UP:   rate_up_q   <= cfg_data;
				srg_pkg::REG_RATE_DOWN: rate_down_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register and seconds calculation
	srg_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_ch  (step_ch),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// accumulator, clamp and result register
	srg_ramp_stage u_ramp_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.rate_up   (rate_up_q),
		.rate_down (rate_down_q),
		.out_ready (result_ch.ready),
		.take      (take),
		.valid_s2  (valid_s2),
		.result_s2 (result_s2)
	);

	assign result_ch.valid     = valid_s2;
	assign result_ch.ramp_out  = result_s2.ramp_out;
	assign result_ch.at_target = result_s2.at_target;

endmodule

`default_nettype wire

>>> hw/rtl/srg_in_stage.sv
// srg_in_stage: input register; turns elapsed timer ticks into whole seconds
// depends on srg_pkg and srg_step_if
`default_nettype none

module srg_in_stage (
	input  wire logic         clk,
	input  wire logic         arst_n,
	srg_step_if.sink          step_ch,
	input  wire logic         take,
	output logic              valid_s1,
	output srg_pkg::item_t    item_s1
);

	logic [srg_pkg::TIMER_W-1:0] last_time_q;
	logic [srg_pkg::TIMER_W-1:0] elapsed;
	logic [srg_pkg::TIMER_W+srg_pkg::RECIP_W-1:0] quot_prod;
	logic [srg_pkg::TIMER_W-1:0] seconds;
	logic accept;

	assign step_ch.ready = !valid_s1 || take;
	assign accept        = step_ch.valid && step_ch.ready;

	// wrapped tick difference, divided by reciprocal multiply
	assign elapsed   = step_ch.timer_now - last_time_q;
	assign quot_prod = {{srg_pkg::RECIP_W{1'b0}}, elapsed} *
		{{srg_pkg::TIMER_W{1'b0}}, srg_pkg::TICK_RECIP};
	assign seconds   = quot_prod[srg_pkg::RECIP_SHIFT +: srg_pkg::TIMER_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			last_time_q <= '0;
		end else begin
			if (accept) begin
				valid_s1    <= 1'b1;
				last_time_q <= step_ch.timer_now;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.operation    <= step_ch.operation;
			item_s1.target_value <= step_ch.target_value;
			item_s1.seconds      <= (step_ch.operation == srg_pkg::OP_PRESET) ? '0 : seconds;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/srg_ramp_stage.sv
// srg_ramp_stage: 16.16 accumulator update, target clamp and result register
// depends on srg_pkg
`default_nettype none

module srg_ramp_stage (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         valid_s1,
	input  wire srg_pkg::item_t               item_s1,
	input  wire logic [srg_pkg::RATE_W-1:0]   rate_up,
	input  wire logic [srg_pkg::RATE_W-1:0]   rate_down,
	input  wire logic                         out_ready,
	output logic                              take,
	output logic                              valid_s2,
	output srg_pkg::result_t                  result_s2
);

	localparam int unsigned ACC_W = srg_pkg::VALUE_W + srg_pkg::FRAC_W + 2;
	localparam int unsigned HI_W  = ACC_W - srg_pkg::FRAC_W;
	localparam int unsigned MOV_W = srg_pkg::RATE_W + srg_pkg::TIMER_W;

	logic signed [srg_pkg::VALUE_W-1:0] value_q;
	logic [srg_pkg::FRAC_W-1:0]         frac_q;

	logic                               rising;
	logic [srg_pkg::RATE_W-1:0]         rate;
	logic [MOV_W-1:0]                   move;
	logic signed [ACC_W-1:0]            base;
	logic signed [ACC_W-1:0]            acc;
	logic signed [HI_W-1:0]             hi;
	logic signed [HI_W-1:0]             tgt_ext;
	logic signed [srg_pkg::VALUE_W-1:0] value_nx;
	logic [srg_pkg::FRAC_W-1:0]         frac_nx;

	assign take = valid_s1 && (!valid_s2 || out_ready);

	assign rising  = item_s1.target_value > value_q;
	assign rate    = rising ? rate_up : rate_down;
	assign move    = MOV_W'(rate) * MOV_W'(item_s1.seconds);
	assign base    = {{(ACC_W-srg_pkg::VALUE_W-srg_pkg::FRAC_W){value_q[srg_pkg::VALUE_W-1]}},
		value_q, frac_q};
	assign acc     = rising ? base + $signed({{(ACC_W-MOV_W){1'b0}}, move})
		: base - $signed({{(ACC_W-MOV_W){1'b0}}, move});
	assign hi      = acc[ACC_W-1:srg_pkg::FRAC_W];
	assign tgt_ext = HI_W'(item_s1.target_value);

	always_comb begin
		value_nx = value_q;
		frac_nx  = frac_q;
		if (item_s1.operation == srg_pkg::OP_PRESET) begin
			value_nx = item_s1.target_value;
			frac_nx  = '0;
		end else if (item_s1.target_value != value_q) begin
			frac_nx = acc[srg_pkg::FRAC_W-1:0];
			// saturate at the target, never pass it
			if (rising ? (hi > tgt_ext) : (hi < tgt_ext)) begin
				value_nx = item_s1.target_value;
			end else begin
				value_nx = hi[srg_pkg::VALUE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q  <= '0;
			frac_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				value_q  <= value_nx;
				frac_q   <= frac_nx;
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_s2.ramp_out  <= value_nx;
			result_s2.at_target <= (value_nx == item_s1.target_value);
		end
	end

endmodule

`default_nettype wire
